// ===== rtl/bmhpq_pkg.sv =====
// Shared types and codes for the binary min-heap priority queue.
// Depends on nothing; used by every module under rtl.
package bmhpq_pkg;

  // default number of heap slots
  localparam int unsigned CapacityDef = 64;

  // widths of the entry fields
  localparam int unsigned PrioW  = 8;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned TagW   = 16;
  localparam int unsigned OccW   = 7;
  localparam int unsigned StatW  = 2;
  localparam int unsigned EntryW = PrioW + TimeW + TagW;

  // one stored heap entry, ordered by (prio, treat_time)
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] treat_time;
    logic [PrioW-1:0] prio;
  } entry_t;

  // request kind
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  // result status
  typedef enum logic [StatW-1:0] {
    STAT_PUSHED = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_POPPED = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

endpackage

// ===== rtl/bmhpq_cmp.sv =====
// Shared key comparator: strict less-than on the (prio, treat_time) pair.
// Depends on bmhpq_pkg for the entry type.
module bmhpq_cmp (
  input  bmhpq_pkg::entry_t lhs_i,
  input  bmhpq_pkg::entry_t rhs_i,
  output logic              lt_o
);

  // lexicographic compare, priority in the upper bits of the key
  assign lt_o = {lhs_i.prio, lhs_i.treat_time} < {rhs_i.prio, rhs_i.treat_time};

endmodule

// ===== rtl/bmhpq_store.sv =====
// Heap entry memory: one write port, two registered read ports.
// Depends on bmhpq_pkg for the entry type.
module bmhpq_store #(
  parameter int unsigned Depth = bmhpq_pkg::CapacityDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  bmhpq_pkg::entry_t wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_a_i,
  input  logic [AddrW-1:0]  raddr_b_i,
  output bmhpq_pkg::entry_t rdata_a_o,
  output bmhpq_pkg::entry_t rdata_b_o
);

  bmhpq_pkg::entry_t mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== rtl/binary_min_heap_priority_queue.sv =====
// Bounded binary min-heap priority queue, smallest (prio, treat_time) served first.
// Depends on bmhpq_pkg, bmhpq_store and bmhpq_cmp.
//
// A request is a push (tuser 0) or a pop (tuser 1); each request gives exactly one
// result with a status, the popped entry (zero otherwise) and the occupancy after the
// request. The block takes one request at a time: a push walks the hole up the tree
// with a parent read, then a compare and move, at each level, and a pop first fetches
// root and last entry, then goes down a level at a time (read both children, two
// compares on the single comparator, move) and places the moving entry before it
// exits. A full push or an empty pop goes straight to its result. The steps per level
// are set by the single comparator and the registered read of the entry memory. A
// finished result sits in an output register, so the next request is taken while it
// waits.
module binary_min_heap_priority_queue #(
  parameter int unsigned CAPACITY = bmhpq_pkg::CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // prio[7:0], treat_time[23:8], tag[39:24]
  input  logic        s_axis_tuser,  // opcode[0]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_prio[7:0], out_treat_time[23:8],
                                     // out_tag[39:24], occupancy[46:40], zero[47]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned ChW   = CntW + 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_POP_LD = 8'b0000_0010,
    S_UP_RD  = 8'b0000_0100,
    S_UP_CMP = 8'b0000_1000,
    S_DN_RD  = 8'b0001_0000,
    S_DN_C1  = 8'b0010_0000,
    S_DN_C2  = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  bmhpq_pkg::entry_t mov_q, mov_d;
  logic best_first_q, best_first_d;
  bmhpq_pkg::status_e res_stat_q, res_stat_d;
  bmhpq_pkg::entry_t res_ent_q, res_ent_d;
  logic out_valid_q, out_valid_d;
  bmhpq_pkg::status_e out_stat_q, out_stat_d;
  bmhpq_pkg::entry_t out_ent_q, out_ent_d;
  logic [bmhpq_pkg::OccW-1:0] out_occ_q, out_occ_d;

  // memory and comparator hookup
  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  bmhpq_pkg::entry_t mem_wdata, rdata_a, rdata_b;
  bmhpq_pkg::entry_t cmp_lhs, cmp_rhs;
  logic cmp_lt;

  // request decode
  logic req_fire;
  bmhpq_pkg::opcode_e req_op;
  bmhpq_pkg::entry_t req_ent;

  // child slots of the hole during sift-down
  logic [ChW-1:0] first_slot, second_slot, count_ext;
  logic first_in, second_in;

  assign s_axis_tready = (state_q == S_IDLE);
  assign req_fire      = s_axis_tvalid & s_axis_tready;
  assign req_op        = bmhpq_pkg::opcode_e'(s_axis_tuser);
  assign req_ent       = bmhpq_pkg::entry_t'(s_axis_tdata);

  assign first_slot  = {idx_q, 1'b1};
  assign second_slot = {idx_q, 1'b0};
  assign count_ext   = {1'b0, count_q};
  assign first_in    = (first_slot <= count_ext);
  assign second_in   = (second_slot <= count_ext);

  bmhpq_store #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  bmhpq_cmp u_cmp (
    .lhs_i (cmp_lhs),
    .rhs_i (cmp_rhs),
    .lt_o  (cmp_lt)
  );

  // operand select for the shared comparator
  always_comb begin
    cmp_lhs = mov_q;
    cmp_rhs = rdata_a;
    case (state_q)
      S_UP_CMP: begin
        cmp_lhs = mov_q;
        cmp_rhs = rdata_a;
      end
      S_DN_C1: begin
        cmp_lhs = rdata_a;
        cmp_rhs = mov_q;
      end
      S_DN_C2: begin
        cmp_lhs = rdata_b;
        cmp_rhs = best_first_q ? rdata_a : mov_q;
      end
      default: begin
        cmp_lhs = mov_q;
        cmp_rhs = rdata_a;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    mov_d        = mov_q;
    best_first_d = best_first_q;
    res_stat_d   = res_stat_q;
    res_ent_d    = res_ent_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_stat_d   = out_stat_q;
    out_ent_d    = out_ent_q;
    out_occ_d    = out_occ_q;
    mem_we       = 1'b0;
    mem_waddr    = AddrW'(idx_q - CntW'(1));
    mem_wdata    = mov_q;
    mem_re       = 1'b0;
    mem_raddr_a  = '0;
    mem_raddr_b  = '0;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_ent_d = '0;
          if (req_op == bmhpq_pkg::OP_PUSH) begin
            if (count_q == CntW'(CAPACITY)) begin
              res_stat_d = bmhpq_pkg::STAT_FULL;
              state_d    = S_FIN;
            end else begin
              res_stat_d = bmhpq_pkg::STAT_PUSHED;
              count_d    = count_q + CntW'(1);
              idx_d      = count_q + CntW'(1);
              mov_d      = req_ent;
              state_d    = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_stat_d = bmhpq_pkg::STAT_EMPTY;
              state_d    = S_FIN;
            end else begin
              // fetch root and last entry together
              res_stat_d  = bmhpq_pkg::STAT_POPPED;
              count_d     = count_q - CntW'(1);
              mem_re      = 1'b1;
              mem_raddr_a = '0;
              mem_raddr_b = AddrW'(count_q - CntW'(1));
              state_d     = S_POP_LD;
            end
          end
        end
      end

      S_POP_LD: begin
        res_ent_d = rdata_a;
        mov_d     = rdata_b;
        idx_d     = CntW'(1);
        state_d   = (count_q == '0) ? S_FIN : S_DN_RD;
      end

      // sift-up: read the parent of the hole, or place the entry at the root
      S_UP_RD: begin
        if (idx_q == CntW'(1)) begin
          mem_we  = 1'b1;
          state_d = S_FIN;
        end else begin
          mem_re      = 1'b1;
          mem_raddr_a = AddrW'((idx_q >> 1) - CntW'(1));
          state_d     = S_UP_CMP;
        end
      end

      // parent strictly greater: move it down into the hole; else place the entry
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = rdata_a;
          idx_d     = idx_q >> 1;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end

      // sift-down: read both children of the hole, or place the entry at a leaf
      S_DN_RD: begin
        if (!second_in) begin
          mem_we  = 1'b1;
          state_d = S_FIN;
        end else begin
          mem_re      = 1'b1;
          mem_raddr_a = first_in ? AddrW'(first_slot - ChW'(1)) : '0;
          mem_raddr_b = AddrW'(second_slot - ChW'(1));
          state_d     = S_DN_C1;
        end
      end

      // child at 2i+1 against the moving entry
      S_DN_C1: begin
        best_first_d = first_in & cmp_lt;
        state_d      = S_DN_C2;
      end

      // child at 2i against the best so far, then move
      S_DN_C2: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = rdata_b;
          idx_d     = CntW'(second_slot);
          state_d   = S_DN_RD;
        end else if (best_first_q) begin
          mem_wdata = rdata_a;
          idx_d     = CntW'(first_slot);
          state_d   = S_DN_RD;
        end else begin
          state_d = S_FIN;
        end
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_ent_d   = res_ent_q;
          out_occ_d   = bmhpq_pkg::OccW'(count_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    mov_q        <= mov_d;
    best_first_q <= best_first_d;
    res_stat_q   <= res_stat_d;
    res_ent_q    <= res_ent_d;
    out_stat_q   <= out_stat_d;
    out_ent_q    <= out_ent_d;
    out_occ_q    <= out_occ_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {1'b0, out_occ_q, out_ent_q};

  // checks on the sequencer
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE) && (state_q != S_FIN))
    else $error("memory written outside a sift");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_op == bmhpq_pkg::OP_POP) && (count_q == '0)
    |=> (state_q == S_FIN) && (count_q == '0))
    else $error("empty pop changed the heap");

  a_hole_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DN_RD) |-> (idx_q != '0) && (idx_q <= count_q))
    else $error("sift-down hole out of range");

endmodule

// ===== bench/tb_binary_min_heap_priority_queue.sv =====
`timescale 1ns / 100ps
// Testbench for binary_min_heap_priority_queue: push/pop request stream checked against
// a heap predictor kept in the bench. Depends on bmhpq_pkg and the rtl top level only.
module tb_binary_min_heap_priority_queue;

  localparam int unsigned Capacity   = bmhpq_pkg::CapacityDef;
  localparam int unsigned PrioW      = bmhpq_pkg::PrioW;
  localparam int unsigned TimeW      = bmhpq_pkg::TimeW;
  localparam int unsigned TagW       = bmhpq_pkg::TagW;
  localparam int unsigned OccW       = bmhpq_pkg::OccW;
  localparam int unsigned NumRandom  = 1400;
  localparam int unsigned StuckLimit = 5000;
  localparam int unsigned TailCycles = 60;
  localparam int unsigned MaxReports = 10;

  // shape of one stretch of random requests
  typedef enum int {
    PH_MIXED,
    PH_FILL,
    PH_DRAIN
  } phase_e;

  // how pushed keys are drawn
  typedef enum int {
    KEYS_WIDE,
    KEYS_TIES,
    KEYS_EDGES
  } key_mode_e;

  typedef struct packed {
    bmhpq_pkg::opcode_e op;
    logic [PrioW-1:0]   prio;
    logic [TimeW-1:0]   treat_time;
    logic [TagW-1:0]    tag;
    logic [15:0]        gap;
  } request_t;

  typedef struct packed {
    bmhpq_pkg::status_e status;
    logic [PrioW-1:0]   prio;
    logic [TimeW-1:0]   treat_time;
    logic [TagW-1:0]    tag;
    logic [OccW-1:0]    occupancy;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  binary_min_heap_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // requests waiting to be driven, and results the heap owes
  request_t    req_queue[$];
  result_t     due_results[$];
  int unsigned gen_count = 0;

  // bench copy of the heap, slots 1..model_count in use
  bmhpq_pkg::entry_t model_heap [1:Capacity];
  int unsigned       model_count = 0;

  bit          req_taken = 1'b0;
  bit          res_taken = 1'b0;
  int unsigned stuck_cycles = 0;
  int unsigned err_count = 0;
  int unsigned gap_left = 0;
  bit          gap_loaded = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [PrioW+TimeW-1:0] heap_key(input bmhpq_pkg::entry_t e);
    return {e.prio, e.treat_time};
  endfunction

  // apply one request to the bench heap and work out its result
  task automatic heap_predict(input request_t r, output result_t res);
    int unsigned       node;
    int unsigned       child_a;
    int unsigned       child_b;
    int unsigned       best;
    bmhpq_pkg::entry_t tmp;
    bit                settled;
    res = '0;
    if (r.op == bmhpq_pkg::OP_PUSH) begin
      if (model_count >= Capacity) begin
        res.status = bmhpq_pkg::STAT_FULL;
      end else begin
        model_count++;
        tmp.prio       = r.prio;
        tmp.treat_time = r.treat_time;
        tmp.tag        = r.tag;
        model_heap[model_count] = tmp;
        // sift up while the parent is strictly greater
        node = model_count;
        while (node > 1 && heap_key(model_heap[node / 2]) > heap_key(model_heap[node])) begin
          tmp                  = model_heap[node / 2];
          model_heap[node / 2] = model_heap[node];
          model_heap[node]     = tmp;
          node                 = node / 2;
        end
        res.status = bmhpq_pkg::STAT_PUSHED;
      end
    end else if (model_count == 0) begin
      res.status = bmhpq_pkg::STAT_EMPTY;
    end else begin
      res.prio       = model_heap[1].prio;
      res.treat_time = model_heap[1].treat_time;
      res.tag        = model_heap[1].tag;
      model_heap[1]  = model_heap[model_count];
      model_count--;
      // sift down, right child tested first, swap only on strictly smaller
      node    = 1;
      settled = 1'b0;
      while (!settled) begin
        child_a = 2 * node + 1;
        child_b = 2 * node;
        best    = node;
        if (child_a <= model_count && heap_key(model_heap[child_a]) < heap_key(model_heap[best]))
          best = child_a;
        if (child_b <= model_count && heap_key(model_heap[child_b]) < heap_key(model_heap[best]))
          best = child_b;
        if (best == node) begin
          settled = 1'b1;
        end else begin
          tmp              = model_heap[node];
          model_heap[node] = model_heap[best];
          model_heap[best] = tmp;
          node             = best;
        end
      end
      res.status = bmhpq_pkg::STAT_POPPED;
    end
    res.occupancy = model_count[OccW-1:0];
  endtask

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_request(input bmhpq_pkg::opcode_e op, input logic [PrioW-1:0] p,
                             input logic [TimeW-1:0] t, input logic [TagW-1:0] g,
                             input bit calm);
    request_t r;
    r.op         = op;
    r.prio       = p;
    r.treat_time = t;
    r.tag        = g;
    r.gap        = 16'(pick_gap(calm));
    req_queue.push_back(r);
    if (op == bmhpq_pkg::OP_PUSH && gen_count < Capacity) gen_count++;
    else if (op == bmhpq_pkg::OP_POP && gen_count > 0) gen_count--;
  endtask

  task automatic add_random(input bmhpq_pkg::opcode_e op, input key_mode_e mode,
                            input bit calm);
    logic [PrioW-1:0] p;
    logic [TimeW-1:0] t;
    p = PrioW'($urandom);
    t = TimeW'($urandom);
    if (mode == KEYS_TIES) begin
      p = PrioW'($urandom_range(0, 3));
      t = TimeW'($urandom_range(0, 3));
    end else if (mode == KEYS_EDGES) begin
      p = $urandom_range(0, 1) ? '1 : '0;
      t = $urandom_range(0, 1) ? '1 : TimeW'($urandom_range(0, 1));
    end
    add_request(op, p, t, TagW'($urandom), calm);
  endtask

  // request driver, changes at the falling edge
  always @(negedge clk_i) begin
    request_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (req_queue.size() > 0) begin
        if (!gap_loaded) begin
          gap_left   = req_queue[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          r          = req_queue.pop_front();
          gap_loaded = 1'b0;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {r.tag, r.treat_time, r.prio};
          s_axis_tuser  <= r.op;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure: runs of ready high, some long, and stalls
  always @(negedge clk_i) begin
    int unsigned roll;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        m_axis_tready <= 1'b1;
        hold_left = $urandom_range(0, 19);
      end else if (roll < 72) begin
        m_axis_tready <= 1'b1;
        hold_left = $urandom_range(40, 300);
      end else begin
        m_axis_tready <= 1'b0;
        hold_left = pick_gap(1'b0);
      end
    end
  end

  // monitor: predict on request handshake, check on result handshake
  always @(posedge clk_i) begin
    request_t acc;
    result_t  want;
    result_t  got;
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    res_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (req_taken) begin
      acc            = '0;
      acc.op         = bmhpq_pkg::opcode_e'(s_axis_tuser);
      acc.prio       = s_axis_tdata[7:0];
      acc.treat_time = s_axis_tdata[23:8];
      acc.tag        = s_axis_tdata[39:24];
      heap_predict(acc, want);
      due_results.push_back(want);
    end
    if (res_taken) begin
      got.status     = bmhpq_pkg::status_e'(m_axis_tuser);
      got.prio       = m_axis_tdata[7:0];
      got.treat_time = m_axis_tdata[23:8];
      got.tag        = m_axis_tdata[39:24];
      got.occupancy  = m_axis_tdata[46:40];
      if (due_results.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("%0t: result with no request pending: status %0d occ %0d",
                   $realtime, got.status, got.occupancy);
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status || got.prio !== want.prio ||
            got.treat_time !== want.treat_time || got.tag !== want.tag ||
            got.occupancy !== want.occupancy) begin
          err_count++;
          if (err_count <= MaxReports)
            $display({"%0t: mismatch exp status %0d prio %0d time %0d tag %0d occ %0d",
                      " / got status %0d prio %0d time %0d tag %0d occ %0d"},
                     $realtime, want.status, want.prio, want.treat_time, want.tag,
                     want.occupancy, got.status, got.prio, got.treat_time, got.tag,
                     got.occupancy);
        end
      end
    end
    // watchdog on handshake activity
    if (req_taken || res_taken) stuck_cycles = 0;
    else if (rst_ni) stuck_cycles++;
  end

  initial begin
    int unsigned made;
    int unsigned phase_no;
    int unsigned len;
    int unsigned push_pct;
    phase_e      kind;
    key_mode_e   mode;
    bit          calm;

    // directed: empty pop, field extremes, equal keys, child tie
    add_request(bmhpq_pkg::OP_POP, 8'd0, 16'd0, 16'd0, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'h00, 16'h0000, 16'h0000, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'h00, 16'h0000, 16'h0001, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'h00, 16'hFFFF, 16'hA5A5, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'hFF, 16'h0000, 16'h5A5A, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'h80, 16'h8000, 16'h8001, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'h7F, 16'h7FFF, 16'h7FFE, 1'b0);
    repeat (8) add_request(bmhpq_pkg::OP_POP, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'd1, 16'd0, 16'h0011, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'd5, 16'd5, 16'h00B0, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'd5, 16'd5, 16'h00C0, 1'b0);
    add_request(bmhpq_pkg::OP_PUSH, 8'd9, 16'd0, 16'h0099, 1'b0);
    repeat (4) add_request(bmhpq_pkg::OP_POP, 8'd0, 16'd0, 16'd0, 1'b0);

    // random stretches: fill to full, drain to empty, and mixed traffic
    made     = 0;
    phase_no = 0;
    while (made < NumRandom) begin
      kind = phase_no == 0 ? PH_FILL : phase_no == 1 ? PH_DRAIN : phase_e'($urandom_range(0, 2));
      len  = $urandom_range(0, 99);
      mode = len < 55 ? KEYS_WIDE : len < 85 ? KEYS_TIES : KEYS_EDGES;
      calm = ($urandom_range(0, 4) == 0);
      case (kind)
        PH_FILL: begin
          while (gen_count < Capacity) begin
            add_random($urandom_range(0, 9) == 0 ? bmhpq_pkg::OP_POP : bmhpq_pkg::OP_PUSH,
                       mode, calm);
            made++;
          end
          repeat ($urandom_range(1, 4)) begin
            add_random(bmhpq_pkg::OP_PUSH, mode, calm);
            made++;
          end
        end
        PH_DRAIN: begin
          while (gen_count > 0) begin
            add_random($urandom_range(0, 9) == 0 ? bmhpq_pkg::OP_PUSH : bmhpq_pkg::OP_POP,
                       mode, calm);
            made++;
          end
          repeat ($urandom_range(1, 3)) begin
            add_random(bmhpq_pkg::OP_POP, mode, calm);
            made++;
          end
        end
        default: begin
          len      = $urandom_range(20, 80);
          push_pct = $urandom_range(35, 70);
          repeat (len) begin
            add_random($urandom_range(0, 99) < push_pct ? bmhpq_pkg::OP_PUSH
                                                         : bmhpq_pkg::OP_POP,
                       mode, calm);
            made++;
          end
        end
      endcase
      phase_no++;
    end

    // reset, released at a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(req_queue.size() == 0 && !s_axis_tvalid && due_results.size() == 0) &&
           stuck_cycles < StuckLimit)
      @(posedge clk_i);

    if (stuck_cycles >= StuckLimit) begin
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               stuck_cycles, due_results.size());
      $display("CHECKS FAILED");
    end else begin
      repeat (TailCycles) @(posedge clk_i);
      if (err_count == 0 && due_results.size() == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

endmodule
